// File: src/spi_header_sync_and_budget_core_macros.svh
// ----------------------------------------------------------------------------
// SPI header sync and budget - assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SPI_HEADER_SYNC_AND_BUDGET_CORE_MACROS_SVH
`define SPI_HEADER_SYNC_AND_BUDGET_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SHSB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shsb check failed");

// Next-cycle implication, disabled while in reset
`define SHSB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shsb check failed");

`endif

// File: src/shsb_pkg.sv
// ----------------------------------------------------------------------------
// SPI header sync and budget - package
// Request and status codes, phase encoding, item structs and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package shsb_pkg;

  // Defaults and fixed constants
  localparam int          NUM_CHANNELS_DEF = 2;
  localparam int          HEADER_BYTES     = 8;
  localparam logic [15:0] HEADER_BYTES_W   = 16'(HEADER_BYTES);
  localparam logic [15:0] SYNC_MARKER      = 16'hFECA;
  localparam logic [14:0] MAX_WORDS0_RST   = 15'd1024;
  localparam logic [14:0] MAX_WORDS1_RST   = 15'd20480;
  localparam logic [13:0] SYNC_LIMIT_RST   = 14'd10000;

  // Request codes
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_WORD  = 2'd1,
    REQ_XFER  = 2'd2,
    REQ_END   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_HUNTING    = 4'd1,
    ST_WORD_TAKEN = 4'd2,
    ST_HDR_DONE   = 4'd3,
    ST_SYNC_FAIL  = 4'd4,
    ST_CLAMPED    = 4'd5,
    ST_PADDED     = 4'd6,
    ST_UNEXPECTED = 4'd7,
    ST_REST_UNLIM = 4'd8
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_WORDS0 = 2'd0,
    CFG_MAX_WORDS1 = 2'd1,
    CFG_SYNC_LIMIT = 2'd2
  } cfg_idx_t;

  // Header phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HUNT = 5'b00010,
    PH_ATN  = 5'b00100,
    PH_TX   = 5'b01000,
    PH_RX   = 5'b10000
  } phase_t;

  // Accepted request
  typedef struct packed {
    logic [1:0]  req_type;
    logic        chan;
    logic [15:0] rx_word;
    logic [15:0] req_bytes;
    logic        use_rest;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] byte_count;
    logic [7:0]  atn_code;
    logic [15:0] budget_left;
    logic        budget_limited;
  } out_item_t;

  // Header word count to byte count: swap, cap, double, drop header bytes
  function automatic logic [15:0] count_to_bytes(input logic [15:0] word,
                                                 input logic [14:0] cap);
    logic [15:0] swapped;
    logic [14:0] capped;
    logic [15:0] doubled;
    swapped = {word[7:0], word[15:8]};
    capped  = (swapped > {1'b0, cap}) ? cap : swapped[14:0];
    doubled = {capped, 1'b0};
    return (doubled >= HEADER_BYTES_W) ? (doubled - HEADER_BYTES_W) : 16'd0;
  endfunction

endpackage

`default_nettype wire

// File: src/shsb_if.sv
// ----------------------------------------------------------------------------
// SPI header sync and budget - channel interfaces
// Valid/ready request, result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel
interface shsb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        chan;
  logic [15:0] rx_word;
  logic [15:0] req_bytes;
  logic        use_rest;

  modport source (output valid, req_type, chan, rx_word, req_bytes, use_rest,
                  input ready);
  modport sink   (input valid, req_type, chan, rx_word, req_bytes, use_rest,
                  output ready);
endinterface

// Result channel
interface shsb_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] byte_count;
  logic [7:0]  atn_code;
  logic [15:0] budget_left;
  logic        budget_limited;

  modport source (output valid, status, byte_count, atn_code, budget_left,
                  budget_limited, input ready);
  modport sink   (input valid, status, byte_count, atn_code, budget_left,
                  budget_limited, output ready);
endinterface

// Configuration write channel
interface shsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/spi_header_sync_and_budget_core.sv
// ----------------------------------------------------------------------------
// SPI header sync and budget core
// Per-chip-select header hunt, header decode and transfer byte budgeting.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch   : requests (start, header word, transfer, end) for one chip select.
//  out_ch  : exactly one result per request, in request order.
//  cfg_ch  : register writes (word caps per channel, sync limit); always ready,
//            write only while no request is in flight.
//  Path    : an accepted request is held in the input register, then its
//            result is registered in the output register for out_ch.
//  Rate    : one request per cycle unless out_ch stalls. The per-channel state
//            update is a compare, clamp and subtract done in the cycle the
//            request leaves the input register, so back-to-back requests on
//            the same channel see each other's results.
//  Stall   : while out_ch is stalled, the input register still takes one more
//            request; in_ch.ready drops once both registers hold items.
//  Reset   : rst_n (synchronous, active low) empties both registers, puts all
//            channels idle with unlimited budget and loads the default caps
//            and sync limit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_header_sync_and_budget_core_macros.svh"

module spi_header_sync_and_budget_core
  import shsb_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  shsb_in_if.sink     in_ch,
  shsb_out_if.source  out_ch,
  shsb_cfg_if.sink    cfg_ch
);

  localparam logic [1:0] NCH = 2'(NUM_CHANNELS);

  // Configuration registers
  logic [14:0] max_words0_r, max_words0_nxt;
  logic [14:0] max_words1_r, max_words1_nxt;
  logic [13:0] sync_limit_r, sync_limit_nxt;

  // Pipeline registers
  in_item_t    s1_r;
  logic        s1_valid_r, s1_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        s1_go;
  logic        in_take;

  // Per-channel state
  phase_t      phase_r   [NUM_CHANNELS];
  phase_t      phase_nxt [NUM_CHANNELS];
  logic [13:0] miss_r    [NUM_CHANNELS];
  logic [13:0] miss_nxt  [NUM_CHANNELS];
  logic [7:0]  atn_r     [NUM_CHANNELS];
  logic [7:0]  atn_nxt   [NUM_CHANNELS];
  logic [15:0] txp_r     [NUM_CHANNELS];
  logic [15:0] txp_nxt   [NUM_CHANNELS];
  logic [15:0] bud_r     [NUM_CHANNELS];
  logic [15:0] bud_nxt   [NUM_CHANNELS];
  logic        bval_r    [NUM_CHANNELS];
  logic        bval_nxt  [NUM_CHANNELS];

  // Selected channel view and its update
  logic [1:0]  sel_idx;
  logic        chan_ok;
  phase_t      cur_phase, new_phase;
  logic [13:0] cur_miss, new_miss;
  logic [7:0]  cur_atn, new_atn;
  logic [15:0] cur_txp, new_txp;
  logic [15:0] cur_bud, new_bud;
  logic        cur_bval, new_bval;
  logic [14:0] cap;
  logic [14:0] miss_inc;
  logic [15:0] word_bytes;
  status_t     res_status;
  logic [15:0] res_bytes;

  // Handshakes
  assign s1_go        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_comb begin
    max_words0_nxt = max_words0_r;
    max_words1_nxt = max_words1_r;
    sync_limit_nxt = sync_limit_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_MAX_WORDS0: max_words0_nxt = cfg_ch.data;
        CFG_MAX_WORDS1: max_words1_nxt = cfg_ch.data;
        CFG_SYNC_LIMIT: sync_limit_nxt = cfg_ch.data[13:0];
        default: ;
      endcase
    end
  end

  // Read the addressed channel's state
  assign sel_idx = {1'b0, s1_r.chan};
  assign chan_ok = sel_idx < NCH;

  always_comb begin
    cur_phase = PH_IDLE;
    cur_miss  = '0;
    cur_atn   = '0;
    cur_txp   = '0;
    cur_bud   = '0;
    cur_bval  = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (sel_idx == 2'(c)) begin
        cur_phase = phase_r[c];
        cur_miss  = miss_r[c];
        cur_atn   = atn_r[c];
        cur_txp   = txp_r[c];
        cur_bud   = bud_r[c];
        cur_bval  = bval_r[c];
      end
    end
  end

  assign cap        = s1_r.chan ? max_words1_r : max_words0_r;
  assign miss_inc   = {1'b0, cur_miss} + 15'd1;
  assign word_bytes = count_to_bytes(s1_r.rx_word, cap);

  // Request processing for the addressed channel
  always_comb begin
    new_phase  = cur_phase;
    new_miss   = cur_miss;
    new_atn    = cur_atn;
    new_txp    = cur_txp;
    new_bud    = cur_bud;
    new_bval   = cur_bval;
    res_status = ST_OK;
    res_bytes  = '0;
    unique case (req_t'(s1_r.req_type))
      REQ_START: begin
        new_bval   = 1'b0;
        new_bud    = '0;
        new_miss   = '0;
        new_phase  = PH_HUNT;
        res_status = ST_HUNTING;
      end
      REQ_WORD: begin
        unique case (cur_phase)
          PH_HUNT: begin
            if (s1_r.rx_word == SYNC_MARKER) begin
              new_phase  = PH_ATN;
              res_status = ST_WORD_TAKEN;
            end else if (miss_inc >= {1'b0, sync_limit_r}) begin
              new_phase  = PH_IDLE;
              new_miss   = '0;
              res_status = ST_SYNC_FAIL;
            end else begin
              new_miss   = miss_inc[13:0];
              res_status = ST_HUNTING;
            end
          end
          PH_ATN: begin
            new_atn    = s1_r.rx_word[15:8];
            new_phase  = PH_TX;
            res_status = ST_WORD_TAKEN;
          end
          PH_TX: begin
            new_txp    = word_bytes;
            new_phase  = PH_RX;
            res_status = ST_WORD_TAKEN;
          end
          PH_RX: begin
            new_bud    = (cur_txp > word_bytes) ? cur_txp : word_bytes;
            new_bval   = 1'b1;
            new_phase  = PH_IDLE;
            res_status = ST_HDR_DONE;
          end
          default: res_status = ST_UNEXPECTED;
        endcase
      end
      REQ_XFER: begin
        if (s1_r.use_rest) begin
          if (cur_bval) begin
            res_bytes = cur_bud;
            new_bud   = '0;
          end else begin
            res_status = ST_REST_UNLIM;
          end
        end else if (cur_bval && (s1_r.req_bytes > cur_bud)) begin
          res_bytes  = cur_bud;
          new_bud    = '0;
          res_status = ST_CLAMPED;
        end else begin
          res_bytes = s1_r.req_bytes;
          if (cur_bval) begin
            new_bud = cur_bud - s1_r.req_bytes;
          end
        end
      end
      REQ_END: begin
        if (cur_bval && (cur_bud != 16'd0)) begin
          res_bytes  = cur_bud;
          res_status = ST_PADDED;
        end
        new_bval = 1'b0;
        new_bud  = '0;
      end
      default: res_status = ST_UNEXPECTED;
    endcase
  end

  // Write back to the addressed channel
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      phase_nxt[c] = phase_r[c];
      miss_nxt[c]  = miss_r[c];
      atn_nxt[c]   = atn_r[c];
      txp_nxt[c]   = txp_r[c];
      bud_nxt[c]   = bud_r[c];
      bval_nxt[c]  = bval_r[c];
      if (s1_go && chan_ok && (sel_idx == 2'(c))) begin
        phase_nxt[c] = new_phase;
        miss_nxt[c]  = new_miss;
        atn_nxt[c]   = new_atn;
        txp_nxt[c]   = new_txp;
        bud_nxt[c]   = new_bud;
        bval_nxt[c]  = new_bval;
      end
    end
  end

  // Result and valid flags
  always_comb begin
    out_nxt = out_r;
    if (s1_go) begin
      if (chan_ok) begin
        out_nxt.status         = res_status;
        out_nxt.byte_count     = res_bytes;
        out_nxt.atn_code       = new_atn;
        out_nxt.budget_left    = new_bval ? new_bud : 16'd0;
        out_nxt.budget_limited = new_bval;
      end else begin
        out_nxt                = '0;
        out_nxt.status         = ST_UNEXPECTED;
      end
    end
    s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_go ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      max_words0_r <= MAX_WORDS0_RST;
      max_words1_r <= MAX_WORDS1_RST;
      sync_limit_r <= SYNC_LIMIT_RST;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      max_words0_r <= max_words0_nxt;
      max_words1_r <= max_words1_nxt;
      sync_limit_r <= sync_limit_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= '{req_type:  in_ch.req_type,
                chan:      in_ch.chan,
                rx_word:   in_ch.rx_word,
                req_bytes: in_ch.req_bytes,
                use_rest:  in_ch.use_rest};
    end
    out_r <= out_nxt;
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (!rst_n) begin
        phase_r[c] <= PH_IDLE;
        miss_r[c]  <= '0;
        atn_r[c]   <= '0;
        txp_r[c]   <= '0;
        bud_r[c]   <= '0;
        bval_r[c]  <= 1'b0;
      end else begin
        phase_r[c] <= phase_nxt[c];
        miss_r[c]  <= miss_nxt[c];
        atn_r[c]   <= atn_nxt[c];
        txp_r[c]   <= txp_nxt[c];
        bud_r[c]   <= bud_nxt[c];
        bval_r[c]  <= bval_nxt[c];
      end
    end
  end

  // Output port
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.byte_count     = out_r.byte_count;
  assign out_ch.atn_code       = out_r.atn_code;
  assign out_ch.budget_left    = out_r.budget_left;
  assign out_ch.budget_limited = out_r.budget_limited;

  // Assertions
  `SHSB_ASSERT_NXT(a_s1_held, s1_valid_r && !s1_go, s1_valid_r)
  `SHSB_ASSERT_IMP(a_unlim_zero,
                   out_valid_r && !out_r.budget_limited,
                   out_r.budget_left == 16'd0)
  `SHSB_ASSERT_IMP(a_clamp_empties,
                   out_valid_r && (out_r.status == ST_CLAMPED),
                   out_r.budget_limited && (out_r.budget_left == 16'd0))

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane_chk
    `SHSB_ASSERT_NXT(a_start_hunts,
                     s1_go && chan_ok && (s1_r.req_type == REQ_START) &&
                       (sel_idx == 2'(g)),
                     phase_r[g] == PH_HUNT)
  end

endmodule

`default_nettype wire
